// ===== rtl/bcp_pkg.sv =====
// ----------------------------------------------------------------------------
// bcp_pkg
// Shared constants, codes and types for the binned cut pileup block.
// ----------------------------------------------------------------------------
`default_nettype none

package bcp_pkg;

  // Number of bins; the difference store holds one extra entry past the end.
  localparam int unsigned NUM_BINS   = 65536;
  localparam int unsigned STORE_DEPTH = NUM_BINS + 1;
  localparam int unsigned ADDR_W     = $clog2(STORE_DEPTH);

  // Field widths
  localparam int unsigned COORD_W = 30;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned VAL_W   = 47;
  localparam int unsigned REACH_W = 31;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned STAT_W  = 2;

  // Configuration register indexes
  localparam logic REG_BIN_WIDTH = 1'b0;
  localparam logic REG_EXT_SIZE  = 1'b1;

  // Item kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SIG   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TOO_MANY = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CUT,
    ST_DIV,
    ST_CHECK,
    ST_RD,
    ST_WR,
    ST_RREQ,
    ST_RSUM,
    ST_OUT
  } state_e;

endpackage : bcp_pkg

`default_nettype wire

// ===== rtl/bcp_ram.sv =====
// ----------------------------------------------------------------------------
// bcp_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bcp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule : bcp_ram

`default_nettype wire

// ===== rtl/binned_cut_pileup.sv =====
// ----------------------------------------------------------------------------
// binned_cut_pileup
// Binned pileup of widened fragment cut sites over a difference store.
//
// Input channel (in_valid_i/in_ready_o): one transaction per item. An add
// item (kind 0) gives two cut sites; each is widened by half the extension
// and its bin range is added into the difference store (+w at the first
// bin, -w after the last). A read item (kind 1) returns one result on the
// output channel: the prefix sum of the next bin, with last_bin on the end.
// Items are handled one at a time. An add keeps the input closed while it
// works through each cut in turn: one setup step, two bit-serial divisions
// by bin_width, one range check and two store read-modify-writes. A read
// keeps the input closed through ST_RREQ, ST_RSUM (skipped for an error
// status) and ST_OUT, from which its result is loaded into the output
// register. Results sit in an output register, so a stalled receiver only
// holds the block when the next read result is ready to be loaded. Reset,
// and every result that ends a readout, starts a clearing pass that zeroes
// all 65537 store entries, one per cycle, during which no item is
// accepted. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module binned_cut_pileup (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_addr_i,
  input  wire logic [bcp_pkg::CFG_W-1:0]     cfg_wdata_i,
  // input items
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          kind_i,
  input  wire logic [bcp_pkg::COORD_W-1:0]   frag_start_i,
  input  wire logic [bcp_pkg::COORD_W-1:0]   frag_end_i,
  input  wire logic [bcp_pkg::CNT_W-1:0]     frag_count_i,
  // results
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [bcp_pkg::IDX_W-1:0]     bin_index_o,
  output logic      [bcp_pkg::VAL_W-1:0]     bin_value_o,
  output logic                               last_bin_o,
  output logic      [bcp_pkg::STAT_W-1:0]    status_o,
  output logic      [bcp_pkg::REACH_W-1:0]   padded_max_coord_o
);
  import bcp_pkg::*;

  localparam int unsigned DIV_STEPS = REACH_W;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  state_e state_q, state_d;

  // configuration
  logic [CFG_W-1:0] bw_q, ext_q;

  // scalar state
  logic [REACH_W-1:0] max_q;
  logic [IDX_W-1:0]   ptr_q;
  logic [SUM_W-1:0]   sum_q;
  logic               any_q, ovf_q;

  // item and cut working registers
  logic [COORD_W-1:0] start_q, end_q;
  logic [CNT_W-1:0]   count_q;
  logic               cut_sel_q;
  logic [REACH_W-1:0] hi_m1_q;
  logic [REACH_W-1:0] b0_q;
  logic               phase_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [ADDR_W-1:0]  clr_addr_q;

  // divider
  logic [REACH_W-1:0] quo_q;
  logic [CFG_W-1:0]   rem_q;
  logic [DCNT_W-1:0]  dcnt_q;
  logic               div_sel_q;

  // pending result
  logic [IDX_W-1:0]   res_idx_q;
  logic [VAL_W-1:0]   res_val_q;
  logic               res_last_q;
  logic [STAT_W-1:0]  res_stat_q;
  logic [REACH_W-1:0] res_coord_q;

  // output register
  logic               out_valid_q;
  logic [IDX_W-1:0]   out_idx_q;
  logic [VAL_W-1:0]   out_val_q;
  logic               out_last_q;
  logic [STAT_W-1:0]  out_stat_q;
  logic [REACH_W-1:0] out_coord_q;

  // store port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [SUM_W-1:0]  ram_wdata, ram_rdata;

  bcp_ram #(
    .Width(SUM_W),
    .Depth(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Cut geometry
  logic signed [31:0] cut_c, half_h, hi_s, lo_s;
  logic               hi_pos, hi_gt_max;
  logic [REACH_W-1:0] lo_clip;

  assign cut_c     = cut_sel_q ? ($signed({2'b00, end_q}) - 32'sd1)
                               : $signed({2'b00, start_q});
  assign half_h    = $signed({17'd0, ext_q[CFG_W-1:1]});
  assign hi_s      = cut_c + half_h;
  assign lo_s      = cut_c - half_h;
  assign hi_pos    = hi_s > 32'sd0;
  assign hi_gt_max = hi_s > $signed({1'b0, max_q});
  assign lo_clip   = lo_s[31] ? '0 : lo_s[REACH_W-1:0];

  // Divider step: restoring, one quotient bit per cycle
  logic [CFG_W:0]     rem_sh, rem_sub;
  logic               q_bit;
  logic [REACH_W-1:0] quo_nx;
  assign rem_sh  = {rem_q, quo_q[REACH_W-1]};
  assign q_bit   = rem_sh >= {1'b0, bw_q};
  assign rem_sub = rem_sh - {1'b0, bw_q};
  assign quo_nx  = {quo_q[REACH_W-2:0], q_bit};
  logic div_done;
  assign div_done = dcnt_q == DCNT_W'(DIV_STEPS - 1);

  // Store indexes for the two store updates
  logic [31:0] idx_cur;
  logic        idx_ok;
  assign idx_cur = phase_q ? ({1'b0, quo_q} + 32'd1) : {1'b0, b0_q};
  assign idx_ok  = idx_cur <= 32'(NUM_BINS);

  logic [SUM_W-1:0] delta;
  assign delta = phase_q ? (SUM_W'(0) - SUM_W'(count_q)) : SUM_W'(count_q);

  // Read checks
  logic        no_sig, too_many, is_last;
  logic [32:0] reach_prod;
  assign no_sig     = !any_q || (max_q == '0) || (bw_q == '0) || (ext_q == '0);
  assign too_many   = ovf_q || ({bw_q, 16'd0} < {1'b0, max_q});
  assign reach_prod = ({16'd0, ({1'b0, ptr_q} + 17'd1)}) * {17'd0, bw_q};
  assign is_last    = reach_prod >= {2'b00, max_q};

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // Next state and store port control
  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    ram_raddr = addr_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        if (clr_addr_q == ADDR_W'(NUM_BINS)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (kind_i == KIND_READ) ? ST_RREQ : ST_CUT;
        end
      end
      ST_CUT: begin
        if (hi_pos && bw_q != '0) begin
          state_d = ST_DIV;
        end else if (!cut_sel_q) begin
          state_d = ST_CUT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done && div_sel_q) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (b0_q > quo_q) begin
          state_d = cut_sel_q ? ST_IDLE : ST_CUT;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        ram_raddr = idx_cur[ADDR_W-1:0];
        if (idx_ok) begin
          state_d = ST_WR;
        end else if (!phase_q) begin
          state_d = ST_RD;
        end else begin
          state_d = cut_sel_q ? ST_IDLE : ST_CUT;
        end
      end
      ST_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata + delta;
        if (!phase_q) begin
          state_d = ST_RD;
        end else begin
          state_d = cut_sel_q ? ST_IDLE : ST_CUT;
        end
      end
      ST_RREQ: begin
        ram_raddr = ADDR_W'(ptr_q);
        state_d   = (no_sig || too_many) ? ST_OUT : ST_RSUM;
      end
      ST_RSUM: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(ptr_q);
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = res_last_q ? ST_CLEAR : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q  <= CFG_W'(50);
      ext_q <= CFG_W'(150);
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_BIN_WIDTH) begin
        bw_q <= cfg_wdata_i;
      end else begin
        ext_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath and scalar state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= '0;
      ptr_q       <= '0;
      sum_q       <= '0;
      any_q       <= 1'b0;
      ovf_q       <= 1'b0;
      clr_addr_q  <= '0;
      cut_sel_q   <= 1'b0;
      div_sel_q   <= 1'b0;
      dcnt_q      <= '0;
      phase_q     <= 1'b0;
      res_last_q  <= 1'b0;
      quo_q       <= '0;
      rem_q       <= '0;
      hi_m1_q     <= '0;
      b0_q        <= '0;
      addr_q      <= '0;
      res_idx_q   <= '0;
      res_val_q   <= '0;
      res_stat_q  <= STAT_OK;
      res_coord_q <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
        end
        ST_IDLE: begin
          clr_addr_q <= '0;
          if (in_valid_i && kind_i == KIND_ADD) begin
            any_q     <= 1'b1;
            cut_sel_q <= 1'b0;
          end
        end
        ST_CUT: begin
          if (hi_gt_max) begin
            max_q <= hi_s[REACH_W-1:0];
          end
          if (hi_pos && bw_q != '0) begin
            quo_q     <= lo_clip;
            rem_q     <= '0;
            dcnt_q    <= '0;
            div_sel_q <= 1'b0;
            hi_m1_q   <= hi_s[REACH_W-1:0] - 1'b1;
          end else begin
            cut_sel_q <= 1'b1;
          end
        end
        ST_DIV: begin
          if (div_done && !div_sel_q) begin
            b0_q      <= quo_nx;
            quo_q     <= hi_m1_q;
            rem_q     <= '0;
            dcnt_q    <= '0;
            div_sel_q <= 1'b1;
          end else begin
            quo_q  <= quo_nx;
            rem_q  <= q_bit ? rem_sub[CFG_W-1:0] : rem_sh[CFG_W-1:0];
            dcnt_q <= dcnt_q + 1'b1;
          end
        end
        ST_CHECK: begin
          phase_q <= 1'b0;
          if (b0_q > quo_q) begin
            cut_sel_q <= 1'b1;
          end
        end
        ST_RD: begin
          addr_q <= idx_cur[ADDR_W-1:0];
          if (!idx_ok) begin
            ovf_q <= 1'b1;
            if (!phase_q) begin
              phase_q <= 1'b1;
            end else begin
              cut_sel_q <= 1'b1;
            end
          end
        end
        ST_WR: begin
          if (!phase_q) begin
            phase_q <= 1'b1;
          end else begin
            cut_sel_q <= 1'b1;
          end
        end
        ST_RREQ: begin
          res_idx_q <= '0;
          res_val_q <= '0;
          if (no_sig) begin
            res_last_q  <= 1'b1;
            res_stat_q  <= STAT_NO_SIG;
            res_coord_q <= '0;
          end else if (too_many) begin
            res_last_q  <= 1'b1;
            res_stat_q  <= STAT_TOO_MANY;
            res_coord_q <= max_q;
          end else begin
            res_last_q  <= is_last;
            res_stat_q  <= STAT_OK;
          end
        end
        ST_RSUM: begin
          sum_q       <= sum_q + ram_rdata;
          res_idx_q   <= ptr_q;
          res_val_q   <= VAL_W'(sum_q + ram_rdata);
          res_coord_q <= max_q;
          ptr_q       <= ptr_q + 1'b1;
        end
        ST_OUT: begin
          if (out_free && res_last_q) begin
            max_q <= '0;
            ptr_q <= '0;
            sum_q <= '0;
            any_q <= 1'b0;
            ovf_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      start_q <= frag_start_i;
      end_q   <= frag_end_i;
      count_q <= frag_count_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      out_idx_q   <= res_idx_q;
      out_val_q   <= res_val_q;
      out_last_q  <= res_last_q;
      out_stat_q  <= res_stat_q;
      out_coord_q <= res_coord_q;
    end
  end

  assign in_ready_o         = state_q == ST_IDLE;
  assign out_valid_o        = out_valid_q;
  assign bin_index_o        = out_idx_q;
  assign bin_value_o        = out_val_q;
  assign last_bin_o         = out_last_q;
  assign status_o           = out_stat_q;
  assign padded_max_coord_o = out_coord_q;

endmodule : binned_cut_pileup

`default_nettype wire
